// ----- hdl/htoa_pkg.sv -----
// Shared types and constants for the hash table with overflow area.
`timescale 1ns / 1ps
package htoa_pkg;

	// Operation codes carried on the kind port.
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_SEARCH = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Result codes driven on the status port.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_PRESENT   = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// Result of one overflow cell's look at the chain walk.
	typedef struct packed {
		logic hit;
		logic used;
	} htoa_cell_stat_t;

endpackage

// ----- hdl/hash_table_with_overflow_area_core.sv -----
// Top level: primary slot table, row of overflow cells and the walking sequencer.
//
//  channel | ports                     | handshake
//  input   | kind, bucket, key         | start high while busy low
//  result  | status                    | done strobe, one cycle
//
// Busy stays high while the sequencer runs: primary check, then the chain walk on a
// primary miss, then the commit and the report; the unused kind skips walk and commit.
// Done rises in the same cycle as busy falls.
// The length of the chain walk through the overflow cells sets how long busy stays high.
// Reset empties all slots at once; no clearing pass is needed.
// The receiver cannot stall: status is shown for one cycle with done.
`timescale 1ns / 1ps
module hash_table_with_overflow_area_core import htoa_pkg::*; #(
	parameter int BUCKETS        = 16,
	parameter int OVERFLOW_SLOTS = 8,
	parameter int KEY_WIDTH      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [3:0]  bucket,
	input  logic [31:0] key,
	output logic        done,
	output logic [1:0]  status
);

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int LW = $clog2(OVERFLOW_SLOTS + 1) + 1;
	localparam int SW = (OVERFLOW_SLOTS > 1) ? $clog2(OVERFLOW_SLOTS) : 1;
	localparam int CW = $clog2(OVERFLOW_SLOTS + 1);
	localparam logic [LW-1:0] NONE = '1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PRIM = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_ACT  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]           state_q;
	logic [1:0]           kind_q;
	logic [BW-1:0]        bkt_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [LW-1:0]        cur_q, prev_q, tail_q, slot_q;
	logic [CW-1:0]        steps_q;
	logic                 found_q, in_prim_q;
	logic [1:0]           status_q;
	logic                 done_q;

	logic [KEY_WIDTH-1:0] pkey_q [BUCKETS];
	logic [BUCKETS-1:0]   pused_q;
	logic [LW-1:0]        plink_q [BUCKETS];

	logic [KEY_WIDTH-1:0] ckey   [OVERFLOW_SLOTS];
	logic [LW-1:0]        clink  [OVERFLOW_SLOTS];
	htoa_cell_stat_t      cstat  [OVERFLOW_SLOTS];
	logic [OVERFLOW_SLOTS-1:0] c_wr_new, c_wr_link, c_clr;
	logic [LW-1:0]        c_new_link;

	logic [BW-1:0]        bidx;
	logic                 cur_ok;
	logic [SW-1:0]        cur_i;
	logic [LW-1:0]        free_idx;
	logic                 free_any;
	logic [LW-1:0]        first;
	logic                 p_wr_key, p_set, p_clr, p_wr_link;
	logic [KEY_WIDTH-1:0] p_new_key;
	logic [LW-1:0]        p_new_link;

	// Bucket index folded into the table, as a small constant lookup.
	always_comb begin
		bidx = '0;
		for (int v = 0; v < 16; v++) begin
			if (bucket == 4'(v)) bidx = BW'(v % BUCKETS);
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign cur_ok = (cur_q < LW'(OVERFLOW_SLOTS));
	assign cur_i  = cur_q[SW-1:0];
	assign first  = plink_q[bkt_q];

	// Row of overflow cells.
	for (genvar g = 0; g < OVERFLOW_SLOTS; g++) begin : g_cell
		htoa_cell #(.KEY_WIDTH(KEY_WIDTH), .LW(LW)) u_cell (
			.clk(clk), .arst_n(arst_n), .cmp_key(key_q),
			.wr_new(c_wr_new[g]), .new_key(key_q),
			.wr_link(c_wr_link[g]), .new_link(c_new_link),
			.clr(c_clr[g]), .key_out(ckey[g]), .link_out(clink[g]),
			.stat(cstat[g]));
	end

	// Lowest free overflow slot.
	always_comb begin
		free_idx = NONE;
		free_any = 1'b0;
		for (int i = OVERFLOW_SLOTS - 1; i >= 0; i--) begin
			if (!cstat[i].used) begin
				free_idx = LW'(i);
				free_any = 1'b1;
			end
		end
	end

	// Updates that the action cycle commits.
	always_comb begin
		c_wr_new   = '0;
		c_wr_link  = '0;
		c_clr      = '0;
		c_new_link = NONE;
		p_wr_key   = 1'b0;
		p_set      = 1'b0;
		p_clr      = 1'b0;
		p_wr_link  = 1'b0;
		p_new_key  = key_q;
		p_new_link = NONE;
		if (state_q == S_ACT) begin
			if (kind_q == KIND_INSERT && !found_q) begin
				if (!pused_q[bkt_q]) begin
					p_wr_key = 1'b1;
					p_set = 1'b1;
					p_wr_link = 1'b1;
				end else if (free_any) begin
					c_wr_new[free_idx[SW-1:0]] = 1'b1;
					c_new_link = free_idx;
					if (tail_q != NONE) c_wr_link[tail_q[SW-1:0]] = 1'b1;
					else begin
						p_wr_link = 1'b1;
						p_new_link = free_idx;
					end
				end
			end else if (kind_q == KIND_REMOVE && found_q) begin
				if (in_prim_q) begin
					if (first < LW'(OVERFLOW_SLOTS)) begin
						p_wr_key = 1'b1;
						p_new_key = ckey[first[SW-1:0]];
						p_wr_link = 1'b1;
						p_new_link = clink[first[SW-1:0]];
						c_clr[first[SW-1:0]] = 1'b1;
					end else begin
						p_clr = 1'b1;
						p_wr_link = 1'b1;
					end
				end else begin
					c_clr[slot_q[SW-1:0]] = 1'b1;
					c_new_link = clink[slot_q[SW-1:0]];
					if (prev_q != NONE) c_wr_link[prev_q[SW-1:0]] = 1'b1;
					else begin
						p_wr_link = 1'b1;
						p_new_link = clink[slot_q[SW-1:0]];
					end
				end
			end
		end
	end

	// Primary slot keys.
	always_ff @(posedge clk) begin
		if (p_wr_key) pkey_q[bkt_q] <= p_new_key;
	end

	// Primary used bits and links.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pused_q <= '0;
			for (int i = 0; i < BUCKETS; i++) plink_q[i] <= NONE;
		end else begin
			if (p_set) pused_q[bkt_q] <= 1'b1;
			if (p_clr) pused_q[bkt_q] <= 1'b0;
			if (p_wr_link) plink_q[bkt_q] <= p_new_link;
		end
	end

	// Operation payload, captured at accept.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q <= kind;
			bkt_q  <= bidx;
			key_q  <= KEY_WIDTH'(key);
		end
	end

	// Sequencer: primary check, chain walk, commit, report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			cur_q     <= NONE;
			prev_q    <= NONE;
			tail_q    <= NONE;
			slot_q    <= NONE;
			steps_q   <= '0;
			found_q   <= 1'b0;
			in_prim_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_PRIM;
				end
				S_PRIM: begin
					cur_q   <= plink_q[bkt_q];
					prev_q  <= NONE;
					tail_q  <= NONE;
					slot_q  <= NONE;
					steps_q <= '0;
					found_q <= pused_q[bkt_q] && (pkey_q[bkt_q] == key_q);
					in_prim_q <= pused_q[bkt_q] && (pkey_q[bkt_q] == key_q);
					if (kind_q == KIND_UNUSED) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_DONE;
					end else if (pused_q[bkt_q] && (pkey_q[bkt_q] == key_q)) begin
						state_q <= S_ACT;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!cur_ok || steps_q == CW'(OVERFLOW_SLOTS)) begin
						state_q <= S_ACT;
					end else if (cstat[cur_i].hit) begin
						found_q <= 1'b1;
						slot_q  <= cur_q;
						state_q <= S_ACT;
					end else begin
						tail_q  <= cur_q;
						prev_q  <= cur_q;
						cur_q   <= clink[cur_i];
						steps_q <= steps_q + 1'b1;
					end
				end
				S_ACT: begin
					state_q <= S_DONE;
					case (kind_q)
						KIND_INSERT: status_q <= found_q ? ST_PRESENT :
							(pused_q[bkt_q] && !free_any) ? ST_FULL : ST_OK;
						default: status_q <= found_q ? ST_OK : ST_NOT_FOUND;
					endcase
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/htoa_cell.sv -----
// One overflow slot: stored key, used bit and link to the next slot of its chain.
`timescale 1ns / 1ps
module htoa_cell import htoa_pkg::*; #(
	parameter int KEY_WIDTH = 32,
	parameter int LW        = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [KEY_WIDTH-1:0] cmp_key,
	input  logic                 wr_new,
	input  logic [KEY_WIDTH-1:0] new_key,
	input  logic                 wr_link,
	input  logic [LW-1:0]        new_link,
	input  logic                 clr,
	output logic [KEY_WIDTH-1:0] key_out,
	output logic [LW-1:0]        link_out,
	output htoa_cell_stat_t      stat
);

	logic [KEY_WIDTH-1:0] key_q;
	logic [LW-1:0]        link_q;
	logic                 used_q;

	// Key store needs no reset; it is only read while the used bit is set.
	always_ff @(posedge clk) begin
		if (wr_new) key_q <= new_key;
	end

	// Used bit and link are control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			link_q <= '1;
		end else if (clr) begin
			used_q <= 1'b0;
			link_q <= '1;
		end else if (wr_new) begin
			used_q <= 1'b1;
			link_q <= '1;
		end else if (wr_link) begin
			link_q <= new_link;
		end
	end

	assign key_out  = key_q;
	assign link_out = link_q;
	assign stat.used = used_q;
	assign stat.hit  = used_q && (key_q == cmp_key);

endmodule

// ----- hdl/htoa_checker.sv -----
// Port-level checker for the hash table core, with its bind.
`timescale 1ns / 1ps
module htoa_checker import htoa_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] kind,
	input logic [1:0] status
);

	// An accepted word makes the core busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept did not raise busy");

	// A result is never shown while idle before it.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without work");

	// The core is free in the same cycle as a result.
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy while reporting");

	// A search never reports full or present.
	a_search_status: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_SEARCH) |-> ##4 (status == ST_OK ||
		status == ST_NOT_FOUND || busy)) else $error("bad search status");

endmodule

bind hash_table_with_overflow_area_core htoa_checker u_htoa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .kind(kind), .status(status));

// ----- test/hash_table_with_overflow_area_core_tb.sv -----
// Self-checking testbench for the hash table core with a shared overflow area.
`timescale 1ns / 1ps
module hash_table_with_overflow_area_core_tb;
	import htoa_pkg::*;

	localparam int NBUCK = 16;
	localparam int NOVF = 8;
	localparam int NONE = -1;

	// Predicts the status of each accepted word and checks it against the core.
	class htoa_scoreboard;
		logic [31:0] pkey[NBUCK];
		bit pused[NBUCK];
		int plink[NBUCK];
		logic [31:0] okey[NOVF];
		bit oused[NOVF];
		int olink[NOVF];
		logic [1:0] pending[$];
		int errors;

		function new();
			errors = 0;
			for (int i = 0; i < NBUCK; i++) begin
				pused[i] = 0;
				plink[i] = NONE;
				pkey[i] = '0;
			end
			for (int i = 0; i < NOVF; i++) begin
				oused[i] = 0;
				olink[i] = NONE;
				okey[i] = '0;
			end
		endfunction

		// Walk the chain of bucket b; returns 1 if k is held.
		function bit lookup(int b, logic [31:0] k, output int slot, output int prev,
				output int tail);
			int cur;
			int prior;
			cur = plink[b];
			prior = NONE;
			slot = NONE;
			prev = NONE;
			tail = NONE;
			if (pused[b] && pkey[b] == k) return 1;
			for (int s = 0; s < NOVF && cur >= 0 && cur < NOVF; s++) begin
				if (oused[cur] && okey[cur] == k) begin
					slot = cur;
					prev = prior;
					return 1;
				end
				tail = cur;
				prior = cur;
				cur = olink[cur];
			end
			return 0;
		endfunction

		function logic [1:0] apply(logic [1:0] op, int b, logic [31:0] k);
			int slot, prev, tail, fr, first;
			bit hit;
			hit = lookup(b, k, slot, prev, tail);
			case (op)
				KIND_INSERT: begin
					if (hit) return ST_PRESENT;
					if (!pused[b]) begin
						pkey[b] = k;
						pused[b] = 1;
						plink[b] = NONE;
						return ST_OK;
					end
					fr = NONE;
					for (int i = NOVF - 1; i >= 0; i--) if (!oused[i]) fr = i;
					if (fr == NONE) return ST_FULL;
					if (tail != NONE) olink[tail] = fr;
					else plink[b] = fr;
					okey[fr] = k;
					oused[fr] = 1;
					olink[fr] = NONE;
					return ST_OK;
				end
				KIND_SEARCH: return hit ? ST_OK : ST_NOT_FOUND;
				KIND_REMOVE: begin
					if (!hit) return ST_NOT_FOUND;
					if (slot == NONE) begin
						first = plink[b];
						if (first != NONE) begin
							pkey[b] = okey[first];
							plink[b] = olink[first];
							oused[first] = 0;
							olink[first] = NONE;
						end else begin
							pused[b] = 0;
							plink[b] = NONE;
						end
						return ST_OK;
					end
					if (prev != NONE) olink[prev] = olink[slot];
					else plink[b] = olink[slot];
					oused[slot] = 0;
					olink[slot] = NONE;
					return ST_OK;
				end
				default: return ST_NOT_FOUND;
			endcase
		endfunction

		function void note_word(logic [1:0] op, logic [3:0] b, logic [31:0] k);
			pending.push_back(apply(op, int'(b), k));
		endfunction

		function void check_status(logic [1:0] got);
			logic [1:0] want;
			if (pending.size() == 0) begin
				report_error($sformatf("status %0d with no word outstanding", got));
				return;
			end
			want = pending.pop_front();
			if (got !== want)
				report_error($sformatf("status %0d, expected %0d", got, want));
		endfunction

		function void report_error(string msg);
			errors++;
			$display("ERROR at %0t: %s", $realtime, msg);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic [1:0] kind;
	logic [3:0] bucket;
	logic [31:0] key;
	logic busy;
	logic done;
	logic [1:0] status;

	htoa_scoreboard sb;
	logic [31:0] key_pool[$];
	int burst_left;

	hash_table_with_overflow_area_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .bucket(bucket), .key(key), .done(done), .status(status)
	);

	// Free-running clock.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Results cannot be held off, so every strobe is checked.
	always @(posedge clk) begin
		if (arst_n && done) sb.check_status(status);
	end

	// Present one word and hold it until the core takes it, with bursty gaps.
	// Start stays high between words of a burst; it drops only for a gap.
	task automatic send_word(logic [1:0] op, logic [3:0] b, logic [31:0] k);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		kind <= op;
		bucket <= b;
		key <= k;
		do @(posedge clk); while (busy);
		sb.note_word(op, b, k);
	endtask

	function automatic logic [31:0] pick_key();
		logic [31:0] k;
		if (key_pool.size() > 0 && $urandom_range(0, 9) < 8)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		k = $urandom();
		if (key_pool.size() < 24) key_pool.push_back(k);
		return k;
	endfunction

	initial begin
		logic [1:0] op;
		logic [3:0] b;
		sb = new();
		burst_left = 0;
		start = 1'b0;
		kind = KIND_SEARCH;
		bucket = '0;
		key = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: key extremes, collisions filling the overflow area, full,
		// duplicate, chain removal, promotion from chain, unused kind.
		send_word(KIND_SEARCH, 4'd0, 32'h0);
		send_word(KIND_INSERT, 4'd0, 32'h0);
		send_word(KIND_INSERT, 4'd0, 32'h0);
		for (int i = 1; i <= 9; i++) send_word(KIND_INSERT, 4'd15, 32'hFFFF_FFF0 + i);
		send_word(KIND_INSERT, 4'd15, 32'hFFFF_FFFF);
		send_word(KIND_SEARCH, 4'd15, 32'hFFFF_FFF9);
		send_word(KIND_REMOVE, 4'd15, 32'hFFFF_FFF4);
		send_word(KIND_REMOVE, 4'd15, 32'hFFFF_FFF1);
		send_word(KIND_INSERT, 4'd15, 32'hFFFF_FFFF);
		send_word(KIND_SEARCH, 4'd15, 32'hFFFF_FFFF);
		send_word(KIND_REMOVE, 4'd15, 32'hFFFF_FFF9);
		send_word(KIND_REMOVE, 4'd0, 32'h5555_AAAA);
		send_word(KIND_UNUSED, 4'd0, 32'h0);
		send_word(KIND_REMOVE, 4'd0, 32'h0);
		send_word(KIND_SEARCH, 4'd0, 32'h0);

		// Random: mostly keys from a small pool over few buckets, so chains grow.
		for (int n = 0; n < 1650; n++) begin
			case ($urandom_range(0, 19))
				0: op = KIND_UNUSED;
				1, 2, 3, 4, 5, 6, 7, 8: op = KIND_INSERT;
				9, 10, 11, 12, 13: op = KIND_SEARCH;
				default: op = KIND_REMOVE;
			endcase
			b = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(0, 2));
			send_word(op, b, pick_key());
			if ($urandom_range(0, 199) == 0) key_pool.delete();
		end
		start <= 1'b0;

		// Drain, then let the last operation settle.
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("hash_table_with_overflow_area_core_tb: done, clean");
		else
			$display("hash_table_with_overflow_area_core_tb: done, errors");
		$finish;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("hash_table_with_overflow_area_core_tb: done, errors");
		$finish;
	end
endmodule
